/* rtl/core/rhc_pkg.sv */
package rhc_pkg;

   // Port widths of the pixel and result fields.
   localparam int IN_W  = 8;
   localparam int HUE_W = 15;
   localparam int SAT_W = 8;
   localparam int BRI_W = 8;

   // Internal channel width and hue fraction bits.
   localparam int CHANNEL_BITS  = 8;
   localparam int HUE_FRAC_BITS = 6;

   localparam longint unsigned CH_MAX   = (64'd1 << CHANNEL_BITS) - 64'd1;
   localparam longint unsigned HUE_UNIT = 64'd60 << HUE_FRAC_BITS;
   localparam longint unsigned HUE_FULL = 64'd360 << HUE_FRAC_BITS;

   // The sector base is below six times the largest delta.
   localparam int BASE_W = $clog2(6 * CH_MAX);
   // The rounded hue numerator is the widest dividend.
   localparam int NUM_W  = $clog2((2 * HUE_FULL + 1) * CH_MAX + 1);
   // Divisors are twice a channel value.
   localparam int DEN_W  = CHANNEL_BITS + 1;
   localparam int HQ_W   = $clog2(HUE_FULL + 1);
   localparam int QUO_W  = (HQ_W > CHANNEL_BITS) ? HQ_W : CHANNEL_BITS;

   // Front stages, then one divider stage per quotient bit.
   localparam int PIPE_STAGES = QUO_W + 2;

   typedef logic [CHANNEL_BITS-1:0] chan_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_lane_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] nq;
      logic [DEN_W-1:0] den;
   } div_part_type;

   typedef struct packed {
      logic     grey;
      chan_type bright;
   } side_type;

   typedef struct packed {
      logic adv;
      logic take_new;
      logic take_skid;
      logic fill_skid;
   } ctrl_type;

endpackage

/* rtl/core/rhc_ctrl.sv */
module rhc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rhc_pkg::ctrl_type ctrl
);

   logic [rhc_pkg::PIPE_STAGES-1:0] valid_ff, valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic skid_valid_ff, skid_valid_in;
   logic out_free, arrive;

   always_comb begin
      out_free       = !rsp_valid_ff || !rsp_stall;
      ctrl.adv       = !skid_valid_ff;
      arrive         = ctrl.adv && valid_ff[rhc_pkg::PIPE_STAGES-1];
      ctrl.take_skid = out_free && skid_valid_ff;
      ctrl.take_new  = out_free && !skid_valid_ff && arrive;
      ctrl.fill_skid = !out_free && arrive;

      rsp_valid_in  = out_free ? (skid_valid_ff || arrive) : 1'b1;
      skid_valid_in = skid_valid_ff ? !out_free : ctrl.fill_skid;

      if (ctrl.adv) begin
         valid_in = {valid_ff[rhc_pkg::PIPE_STAGES-2:0], req_valid};
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/rhc_front.sv */
module rhc_front (
   input  logic                  clock,
   input  logic                  adv,
   input  rhc_pkg::chan_type     red,
   input  rhc_pkg::chan_type     green,
   input  rhc_pkg::chan_type     blue,
   output rhc_pkg::div_lane_type hue_lane,
   output rhc_pkg::div_lane_type sat_lane,
   output rhc_pkg::side_type     side
);

   localparam int BW = rhc_pkg::BASE_W;
   localparam int NW = rhc_pkg::NUM_W;

   rhc_pkg::chan_type mx, mn, delta;
   logic [BW-1:0] base;
   logic [BW-1:0] r_w, g_w, b_w, d_w;

   logic [BW-1:0] base_ff;
   rhc_pkg::chan_type delta_ff, max_ff;

   rhc_pkg::div_lane_type hue_lane_in, sat_lane_in, hue_lane_ff, sat_lane_ff;
   rhc_pkg::side_type side_in, side_ff;

   // First stage: extremes and the sector base.
   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      delta = mx - mn;

      r_w = BW'(red);
      g_w = BW'(green);
      b_w = BW'(blue);
      d_w = BW'(delta);

      if (red == mx) begin
         if (green >= blue) begin
            base = g_w - b_w;
         end else begin
            base = (d_w << 2) + (d_w << 1) - (b_w - g_w);
         end
      end else if (green == mx) begin
         base = (d_w << 1) + b_w - r_w;
      end else begin
         base = (d_w << 2) + r_w - g_w;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         base_ff  <= base;
         delta_ff <= delta;
         max_ff   <= mx;
      end
   end

   // Second stage: rounded dividends and doubled divisors.
   always_comb begin
      hue_lane_in.num = NW'(2 * rhc_pkg::HUE_UNIT) * NW'(base_ff) + NW'(delta_ff);
      hue_lane_in.den = {delta_ff, 1'b0};
      sat_lane_in.num = NW'(2 * rhc_pkg::CH_MAX) * NW'(delta_ff) + NW'(max_ff);
      sat_lane_in.den = {max_ff, 1'b0};
      side_in.grey    = (delta_ff == '0);
      side_in.bright  = max_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hue_lane_ff <= hue_lane_in;
         sat_lane_ff <= sat_lane_in;
         side_ff     <= side_in;
      end
   end

   assign hue_lane = hue_lane_ff;
   assign sat_lane = sat_lane_ff;
   assign side     = side_ff;

endmodule

/* rtl/core/rhc_div.sv */
module rhc_div (
   input  logic                         clock,
   input  logic                         adv,
   input  rhc_pkg::div_lane_type        hue_in,
   input  rhc_pkg::div_lane_type        sat_in,
   input  rhc_pkg::side_type            side_in,
   output logic [rhc_pkg::QUO_W-1:0]    hue_quo,
   output logic [rhc_pkg::QUO_W-1:0]    sat_quo,
   output rhc_pkg::side_type            side_out
);

   localparam int QW = rhc_pkg::QUO_W;
   localparam int DW = rhc_pkg::DEN_W;

   // The top dividend bits start as the partial remainder; they stay below
   // the divisor because every quotient fits in QW bits.
   function automatic rhc_pkg::div_part_type div_start(rhc_pkg::div_lane_type l);
      rhc_pkg::div_part_type p;
      p.rem = DW'(l.num >> QW);
      p.nq  = l.num[QW-1:0];
      p.den = l.den;
      return p;
   endfunction

   // One restoring step: bring down a dividend bit, shift in a quotient bit.
   function automatic rhc_pkg::div_part_type div_step(rhc_pkg::div_part_type p);
      logic [DW:0] t;
      logic ge;
      rhc_pkg::div_part_type r;
      t     = {p.rem, p.nq[QW-1]};
      ge    = (t >= {1'b0, p.den});
      r.den = p.den;
      r.rem = ge ? DW'(t - {1'b0, p.den}) : DW'(t);
      r.nq  = {p.nq[QW-2:0], ge};
      return r;
   endfunction

   rhc_pkg::div_part_type hue_ff [QW];
   rhc_pkg::div_part_type sat_ff [QW];
   rhc_pkg::side_type     side_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      if (s == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (adv) begin
               hue_ff[s]  <= div_step(div_start(hue_in));
               sat_ff[s]  <= div_step(div_start(sat_in));
               side_ff[s] <= side_in;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (adv) begin
               hue_ff[s]  <= div_step(hue_ff[s-1]);
               sat_ff[s]  <= div_step(sat_ff[s-1]);
               side_ff[s] <= side_ff[s-1];
            end
         end
      end
   end

   assign hue_quo  = hue_ff[QW-1].nq;
   assign sat_quo  = sat_ff[QW-1].nq;
   assign side_out = side_ff[QW-1];

endmodule

/* rtl/core/rgb_to_hsv_converter_top.sv */
// RGB to HSV converter, one pixel item per clock while rsp_stall is low.
// Stages: two front stages, one divider stage per quotient bit (15 bits), and
// the output register. Throughput: one item per cycle while rsp_stall is low;
// the rate is set by the pipelined divider lanes.
// Reset (synchronous, active high) clears all valid bits; payload is not reset.

module rgb_to_hsv_converter_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [rhc_pkg::IN_W-1:0]   req_red,
   input  logic [rhc_pkg::IN_W-1:0]   req_green,
   input  logic [rhc_pkg::IN_W-1:0]   req_blue,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [rhc_pkg::HUE_W-1:0]  rsp_hue,
   output logic [rhc_pkg::SAT_W-1:0]  rsp_saturation,
   output logic [rhc_pkg::BRI_W-1:0]  rsp_brightness
);

   localparam int QW = rhc_pkg::QUO_W;

   // The whole pipeline moves on one advance signal. The output register is
   // backed by a one-item skid register, so a stalled result still lets the
   // pipeline take one more step; req_stall comes straight from a flop.
   rhc_pkg::ctrl_type ctrl;

   rhc_pkg::div_lane_type hue_lane, sat_lane;
   rhc_pkg::side_type side_mid, side_end;
   logic [QW-1:0] hue_quo, sat_quo, hue_wrap;

   logic [rhc_pkg::HUE_W-1:0] hue_res, rsp_hue_ff, skid_hue_ff;
   logic [rhc_pkg::SAT_W-1:0] sat_res, rsp_sat_ff, skid_sat_ff;
   logic [rhc_pkg::BRI_W-1:0] bri_res, rsp_bri_ff, skid_bri_ff;

   rhc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   // Front: max, min, delta and the sector base, then the rounded dividends.
   rhc_front u_front (
      .clock    (clock),
      .adv      (ctrl.adv),
      .red      (rhc_pkg::CHANNEL_BITS'(req_red)),
      .green    (rhc_pkg::CHANNEL_BITS'(req_green)),
      .blue     (rhc_pkg::CHANNEL_BITS'(req_blue)),
      .hue_lane (hue_lane),
      .sat_lane (sat_lane),
      .side     (side_mid)
   );

   // Two restoring divider lanes run side by side, one quotient bit a stage.
   rhc_div u_div (
      .clock    (clock),
      .adv      (ctrl.adv),
      .hue_in   (hue_lane),
      .sat_in   (sat_lane),
      .side_in  (side_mid),
      .hue_quo  (hue_quo),
      .sat_quo  (sat_quo),
      .side_out (side_end)
   );

   // A hue that rounds up to a full turn wraps to zero. A grey pixel divided
   // by zero in the hue lane, so its hue and saturation are forced to zero.
   always_comb begin
      if (hue_quo >= QW'(rhc_pkg::HUE_FULL)) begin
         hue_wrap = hue_quo - QW'(rhc_pkg::HUE_FULL);
      end else begin
         hue_wrap = hue_quo;
      end
      if (side_end.grey) begin
         hue_res = '0;
         sat_res = '0;
      end else begin
         hue_res = rhc_pkg::HUE_W'(hue_wrap);
         sat_res = rhc_pkg::SAT_W'(sat_quo);
      end
      bri_res = rhc_pkg::BRI_W'(side_end.bright);
   end

   // Output and skid registers.
   always_ff @(posedge clock) begin
      if (ctrl.take_skid) begin
         rsp_hue_ff <= skid_hue_ff;
         rsp_sat_ff <= skid_sat_ff;
         rsp_bri_ff <= skid_bri_ff;
      end else if (ctrl.take_new) begin
         rsp_hue_ff <= hue_res;
         rsp_sat_ff <= sat_res;
         rsp_bri_ff <= bri_res;
      end
      if (ctrl.fill_skid) begin
         skid_hue_ff <= hue_res;
         skid_sat_ff <= sat_res;
         skid_bri_ff <= bri_res;
      end
   end

   assign rsp_hue        = rsp_hue_ff;
   assign rsp_saturation = rsp_sat_ff;
   assign rsp_brightness = rsp_bri_ff;

endmodule

/* sim/rgb_to_hsv_converter_top_tb.sv */
`timescale 1ns / 1ps

module rgb_to_hsv_converter_top_tb;

   // One converted pixel as the block reports it, plus the pixel that caused it so
   // that a mismatch report can name the input.
   typedef struct packed {
      logic [rhc_pkg::IN_W-1:0]  red;
      logic [rhc_pkg::IN_W-1:0]  green;
      logic [rhc_pkg::IN_W-1:0]  blue;
      logic [rhc_pkg::HUE_W-1:0] hue;
      logic [rhc_pkg::SAT_W-1:0] saturation;
      logic [rhc_pkg::BRI_W-1:0] brightness;
   } hsv_item_type;

   // Every input of the block holds a known value from time zero on.
   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic [rhc_pkg::IN_W-1:0]  req_red        = '0;
   logic [rhc_pkg::IN_W-1:0]  req_green      = '0;
   logic [rhc_pkg::IN_W-1:0]  req_blue       = '0;
   logic                      rsp_stall      = 1'b0;
   logic                      req_stall;
   logic                      rsp_valid;
   logic [rhc_pkg::HUE_W-1:0] rsp_hue;
   logic [rhc_pkg::SAT_W-1:0] rsp_saturation;
   logic [rhc_pkg::BRI_W-1:0] rsp_brightness;

   // Conversions of accepted pixels that have not come out yet, oldest first.
   hsv_item_type pending_hsv_q[$];
   int           mismatch_count = 0;

   // Idling switches. When one is set, that side draws a fresh random wait
   // for every item; when it is clear, that side runs at full rate.
   bit           tx_idle = 1'b0;
   bit           rx_idle = 1'b0;
   int           rx_hold = 0;

   always #5 clock = ~clock;

   rgb_to_hsv_converter_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

   // Works out the hue, saturation and brightness that the block must give for a
   // pixel. The hue is 60 degrees times the position within a six-sector wheel,
   // in units of 1/2^HUE_FRAC_BITS degree. Both quotients round to nearest with
   // ties going up, computed as floor((2n + d) / 2d).
   function automatic hsv_item_type convert_to_hsv(input logic [rhc_pkg::IN_W-1:0] r,
                                                   input logic [rhc_pkg::IN_W-1:0] g,
                                                   input logic [rhc_pkg::IN_W-1:0] b);
      longint unsigned rv, gv, bv, top, bottom, delta, sector, angle, sat;
      hsv_item_type    res;
      rv = r & rhc_pkg::CH_MAX;
      gv = g & rhc_pkg::CH_MAX;
      bv = b & rhc_pkg::CH_MAX;
      top    = rv;
      bottom = rv;
      if (gv > top)    top = gv;
      if (bv > top)    top = bv;
      if (gv < bottom) bottom = gv;
      if (bv < bottom) bottom = bv;
      delta = top - bottom;
      angle = 0;
      sat   = 0;
      // A grey pixel has neither hue nor saturation.
      if (delta != 0) begin
         // Red wins a tie at the top, then green, then blue. In the red sector a
         // negative offset is folded forward by a full turn of six sectors.
         if (rv == top)
            sector = (gv >= bv) ? gv - bv : 6 * delta - (bv - gv);
         else if (gv == top)
            sector = 2 * delta + bv - rv;
         else
            sector = 4 * delta + rv - gv;
         angle = (2 * rhc_pkg::HUE_UNIT * sector + delta) / (2 * delta);
         // Rounding can land exactly on 360 degrees, which is 0 again.
         if (angle >= rhc_pkg::HUE_FULL)
            angle -= rhc_pkg::HUE_FULL;
         sat = (2 * delta * rhc_pkg::CH_MAX + top) / (2 * top);
      end
      res.red        = r;
      res.green      = g;
      res.blue       = b;
      res.hue        = angle[rhc_pkg::HUE_W-1:0];
      res.saturation = sat[rhc_pkg::SAT_W-1:0];
      res.brightness = top[rhc_pkg::BRI_W-1:0];
      return res;
   endfunction

   // Offers one pixel and returns in the time step of the edge that accepts it.
   // It is always entered at a rising edge, so valid gets at most one
   // nonblocking update per time step: it either stays high for a back-to-back
   // item or drops for the drawn gap and rises again at a later edge.
   task automatic send_pixel(input logic [rhc_pkg::IN_W-1:0] r,
                             input logic [rhc_pkg::IN_W-1:0] g,
                             input logic [rhc_pkg::IN_W-1:0] b);
      int gap;
      gap = tx_idle ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      // Signals read right after the edge still hold their pre-edge values, so
      // this sees exactly what the block saw at that edge.
      do @(posedge clock); while (req_stall);
      pending_hsv_q.push_back(convert_to_hsv(r, g, b));
   endtask

   // Drops valid and holds off until every accepted pixel has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_hsv_q.size() != 0)
         @(posedge clock);
   endtask

   // Result side: checks each accepted result against the oldest expectation,
   // then draws how long to stall before the next one. The stall runs whether or
   // not a result is waiting, so it falls on every phase of the pipeline.
   always @(posedge clock) begin
      hsv_item_type want;
      if (reset) begin
         rx_hold = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_hsv_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with nothing pending, hue %0d sat %0d bright %0d",
                        $time, rsp_hue, rsp_saturation, rsp_brightness);
            end else begin
               want = pending_hsv_q.pop_front();
               if (rsp_hue !== want.hue) begin
                  mismatch_count++;
                  $display("%0t: hue for rgb %0d/%0d/%0d, expected %0d, actual %0d",
                           $time, want.red, want.green, want.blue, want.hue, rsp_hue);
               end
               if (rsp_saturation !== want.saturation) begin
                  mismatch_count++;
                  $display("%0t: saturation for rgb %0d/%0d/%0d, expected %0d, actual %0d",
                           $time, want.red, want.green, want.blue, want.saturation,
                           rsp_saturation);
               end
               if (rsp_brightness !== want.brightness) begin
                  mismatch_count++;
                  $display("%0t: brightness for rgb %0d/%0d/%0d, expected %0d, actual %0d",
                           $time, want.red, want.green, want.blue, want.brightness,
                           rsp_brightness);
               end
            end
            rx_hold = rx_idle ? $urandom_range(0, 14) : 0;
         end else if (rx_hold > 0) begin
            rx_hold--;
         end
         rsp_stall <= (rx_hold != 0);
      end
   end

   // Field extremes: black, white, the pure primaries, cyan and magenta, and the
   // smallest nonzero steps off black and off white.
   task automatic test_primary_colors();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd254, 8'd255, 8'd255);
   endtask

   // Grey pixels, and ties for the largest channel in each pairing so that the
   // red-over-green-over-blue precedence is exercised.
   task automatic test_grey_and_ties();
      tx_idle = 1'b1;
      rx_idle = 1'b0;
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1,   8'd1,   8'd1);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd200, 8'd200, 8'd50);
      send_pixel(8'd10,  8'd200, 8'd200);
      send_pixel(8'd200, 8'd10,  8'd200);
      send_pixel(8'd255, 8'd254, 8'd255);
   endtask

   // Red on top with blue above green gives a negative offset that wraps past
   // zero; the nearest cases sit just under 360 degrees.
   task automatic test_negative_hue_wrap();
      tx_idle = 1'b0;
      rx_idle = 1'b1;
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd255, 8'd254, 8'd255);
      send_pixel(8'd200, 8'd10,  8'd100);
      send_pixel(8'd2,   8'd0,   8'd1);
      send_pixel(8'd255, 8'd0,   8'd254);
      send_pixel(8'd3,   8'd1,   8'd2);
   endtask

   // Random pixels in blocks, each block with its own idling pattern drawn at
   // random, which can leave both sides at full rate. Most pixels are shaped toward the cases
   // that matter: greys, ties at the top, tiny spreads that stress rounding, and
   // channels pinned at the rails. Halfway through the sender drains the block.
   task automatic test_random_pixels();
      logic [rhc_pkg::IN_W-1:0] r, g, b, hi, lo;
      int                       base;
      for (int blk = 0; blk < 16; blk++) begin
         tx_idle = 1'($urandom_range(0, 1));
         rx_idle = 1'($urandom_range(0, 1));
         if (blk == 8)
            wait_for_results();
         for (int n = 0; n < 105; n++) begin
            r = rhc_pkg::IN_W'($urandom);
            g = rhc_pkg::IN_W'($urandom);
            b = rhc_pkg::IN_W'($urandom);
            case ($urandom_range(0, 5))
               1: begin
                  g = r;
                  b = r;
               end
               2: begin
                  hi = rhc_pkg::IN_W'($urandom_range(1, 255));
                  lo = rhc_pkg::IN_W'($urandom_range(0, hi));
                  case ($urandom_range(0, 2))
                     0:       begin r = hi; g = hi; b = lo; end
                     1:       begin r = hi; g = lo; b = hi; end
                     default: begin r = lo; g = hi; b = hi; end
                  endcase
               end
               3: begin
                  base = $urandom_range(2, 253);
                  r = rhc_pkg::IN_W'(base + $urandom_range(0, 4) - 2);
                  g = rhc_pkg::IN_W'(base + $urandom_range(0, 4) - 2);
                  b = rhc_pkg::IN_W'(base + $urandom_range(0, 4) - 2);
               end
               4: begin
                  if ($urandom_range(0, 2) == 0) r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                  if ($urandom_range(0, 2) == 0) g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                  if ($urandom_range(0, 2) == 0) b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
               end
               default: ;
            endcase
            send_pixel(r, g, b);
         end
      end
   endtask

   // Main sequence: reset once, run each test in turn, drain, let the pipeline
   // settle to catch stray results, then report.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_primary_colors();
      test_grey_and_ties();
      test_negative_hue_wrap();
      test_random_pixels();
      wait_for_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_hsv_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog. Even with every gap and every stall at its longest the run takes
   // well under a millisecond; this allows several times that.
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

/* files.f */
rtl/core/rhc_pkg.sv
rtl/core/rhc_ctrl.sv
rtl/core/rhc_front.sv
rtl/core/rhc_div.sv
rtl/core/rgb_to_hsv_converter_top.sv
sim/rgb_to_hsv_converter_top_tb.sv
